[sv/cnes_pkg.sv]
// ----------------------------------------------------------------------------
// cnes_pkg
// Shared types, constants and arithmetic helpers of the colored-noise Euler
// step block.
// ----------------------------------------------------------------------------
package cnes_pkg;

	localparam int IDX_W      = 8;
	localparam int DEPTH      = 256;
	localparam int TIME_W     = 48;
	localparam int ROOT_STEPS = 32;

	localparam logic [30:0] RST_STEP  = 31'd167772;
	localparam logic [30:0] RST_RATE  = 31'd16777216;
	localparam logic [24:0] RST_DECAY = 25'd16610279;

	typedef enum logic [1:0] {
		REG_STEP  = 2'd0,
		REG_RATE  = 2'd1,
		REG_DECAY = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic signed [31:0] x;
		logic signed [31:0] f;
		logic signed [31:0] z;
		logic signed [31:0] z0;
		logic               last;
		logic               first;
		logic [TIME_W-1:0] stamp;
	} side_t;

	typedef struct packed {
		logic [63:0] n;
		logic [63:0] r;
	} sq_t;

	// one digit of the restoring square root
	function automatic sq_t sqrt_step(input logic [63:0] n, input logic [63:0] r,
			input logic [63:0] b);
		logic [63:0] s;
		sq_t o;
		s = r + b;
		if (n >= s) begin
			o.n = n - s;
			o.r = (r >> 1) + b;
		end else begin
			o.n = n;
			o.r = r >> 1;
		end
		return o;
	endfunction

	// magnitude >> 24, rounded half away from zero
	function automatic logic [39:0] shr24(input logic [63:0] mag);
		logic [63:0] t;
		t = mag + 64'd8388608;
		return t[63:24];
	endfunction

	function automatic logic signed [41:0] sshr24(input logic [63:0] mag, input logic neg);
		logic signed [41:0] r;
		r = $signed({2'b00, shr24(mag)});
		return neg ? -r : r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
		if (v > 42'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -42'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

endpackage

[sv/cnes_isqrt_pipe.sv]
// ----------------------------------------------------------------------------
// cnes_isqrt_pipe
// Pipelined integer square root of a 62-bit value, one result digit per
// stage, carrying the item's other fields alongside.
// ----------------------------------------------------------------------------
module cnes_isqrt_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [63:0]         in_n,
	input  cnes_pkg::side_t     in_side,
	output logic                out_valid,
	output logic [30:0]         out_root,
	output cnes_pkg::side_t     out_side
);

	localparam int N = cnes_pkg::ROOT_STEPS;

	logic [N:0]      v_s;
	logic [63:0]     n_s [N+1];
	logic [63:0]     r_s [N+1];
	cnes_pkg::side_t side_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[N-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0]    <= in_n;
			r_s[0]    <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_digit
		cnes_pkg::sq_t nx;
		assign nx = cnes_pkg::sqrt_step(n_s[k], r_s[k], 64'd1 << (62 - 2*k));
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1]    <= nx.n;
				r_s[k+1]    <= nx.r;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_root  = r_s[N][30:0];
	assign out_side  = side_s[N];

endmodule

[sv/colored_noise_euler_step.sv]
// ----------------------------------------------------------------------------
// colored_noise_euler_step
// Euler step of a streamed state vector driven by per-element colored noise.
// ----------------------------------------------------------------------------
// One item is taken per clock while in_stall is low; its result is registered
// through the capture stage, the square-root pipeline, stages 3 to 5 and the
// output register. The per-element noise lives in a 256 x 32 memory read ahead
// of use and written back three stages later; when an element index repeats
// within three items the input stalls until the earlier write has landed. After
// reset and after every decay write, a sequential square root forms
// sqrt(1-decay^2) and the input stalls for that time. The noise memory is not
// cleared: the first vector after reset seeds every element it uses.
module colored_noise_euler_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         element_index,
	input  logic signed [31:0] state_value,
	input  logic signed [31:0] drift,
	input  logic [30:0]        diffusion,
	input  logic signed [31:0] noise_sample,
	input  logic signed [31:0] init_noise_sample,
	input  logic               last_element,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_index,
	output logic signed [31:0] new_value,
	output logic               out_last,
	output logic [47:0]        sim_time,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	// configuration
	logic [30:0] step_q, rate_q;
	logic [24:0] decay_q;
	logic        cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= cnes_pkg::RST_STEP;
			rate_q  <= cnes_pkg::RST_RATE;
			decay_q <= cnes_pkg::RST_DECAY;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				cnes_pkg::REG_STEP:  step_q  <= cfg_data;
				cnes_pkg::REG_RATE:  rate_q  <= cfg_data;
				cnes_pkg::REG_DECAY: decay_q <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	// sqrt(1 - decay^2), sequential
	logic          cstart_q;
	logic [63:0]   cbit_q, cn_q, cr_q;
	logic [49:0]   esq;
	logic          comp_busy;
	logic [24:0]   comp;
	cnes_pkg::sq_t cnx;

	assign esq       = decay_q * decay_q;
	assign comp_busy = cstart_q || (cbit_q != '0);
	assign comp      = cr_q[24:0];
	assign cnx       = cnes_pkg::sqrt_step(cn_q, cr_q, cbit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cstart_q <= 1'b1;
			cbit_q   <= '0;
		end else if (cfg_wr && cfg_index == cnes_pkg::REG_DECAY) begin
			cstart_q <= 1'b1;
		end else if (cstart_q) begin
			cstart_q <= 1'b0;
			cbit_q   <= 64'd1 << 48;
		end else if (cbit_q != '0) begin
			cbit_q <= cbit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cstart_q) begin
			cn_q <= (esq >= 50'd1 << 48) ? 64'd0 : 64'((50'd1 << 48) - esq);
			cr_q <= '0;
		end else if (cbit_q != '0) begin
			cn_q <= cnx.n;
			cr_q <= cnx.r;
		end
	end

	// flow control
	logic adv, fadv, hazard, accept, out_valid_q;

	assign adv      = !(out_valid_q && out_stall);
	assign fadv     = adv && !hazard;
	assign in_stall = !fadv || comp_busy;
	assign accept   = in_valid && !in_stall;

	// vector bookkeeping
	logic        first_q;
	logic [47:0] time_q, time_nx;

	assign time_nx = time_q + {17'd0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			time_q  <= '0;
		end else if (accept && last_element) begin
			first_q <= 1'b0;
			time_q  <= time_nx;
		end
	end

	// stage 1: capture
	logic            v_s1;
	cnes_pkg::side_t side_s1;
	logic [30:0]     g_s1;
	logic [61:0]     grate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (fadv)
			v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (fadv && accept) begin
			side_s1.idx   <= element_index;
			side_s1.x     <= state_value;
			side_s1.f     <= drift;
			side_s1.z     <= noise_sample;
			side_s1.z0    <= init_noise_sample;
			side_s1.last  <= last_element;
			side_s1.first <= first_q;
			side_s1.stamp <= last_element ? time_nx : time_q;
			g_s1          <= diffusion;
		end
	end

	assign grate = g_s1 * rate_q;

	// amplitude sqrt(diffusion * rate)
	logic            rv;
	logic [30:0]     amp;
	cnes_pkg::side_t rside;

	cnes_isqrt_pipe u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (fadv),
		.in_valid  (v_s1),
		.in_n      ({2'b00, grate}),
		.in_side   (side_s1),
		.out_valid (rv),
		.out_root  (amp),
		.out_side  (rside)
	);

	// noise memory
	logic signed [31:0] noise_mem [cnes_pkg::DEPTH];
	logic signed [31:0] rd_s3;
	logic               wr_en;
	logic signed [31:0] ne;

	// stage 3..5 registers
	logic               v_s3, v_s4, v_s5;
	cnes_pkg::side_t    side_s3, side_s4;
	logic [62:0]        z0amp_s3;
	logic [55:0]        ampcomp_s3;
	logic signed [31:0] eps_s4;
	logic [31:0]        coef_s4;
	logic [7:0]         idx_s5;
	logic signed [31:0] x_s5;
	logic               last_s5;
	logic [47:0]        stamp_s5;
	logic [63:0]        p1_s5, p3_s5;
	logic [56:0]        p2_s5;
	logic               p1neg_s5, p2neg_s5, p3neg_s5;

	assign hazard = rv && ((v_s3 && side_s3.idx == rside.idx)
		|| (v_s4 && side_s4.idx == rside.idx)
		|| (v_s5 && idx_s5 == rside.idx));

	assign wr_en = adv && v_s5;

	always_ff @(posedge clk) begin
		if (adv)
			rd_s3 <= noise_mem[rside.idx];
		if (wr_en)
			noise_mem[idx_s5] <= ne;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s3        <= rv && !hazard;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// stage 3: choose the noise
	logic signed [31:0] eps;
	logic [39:0]        coef_full;

	assign eps = side_s3.first
		? cnes_pkg::sat32(cnes_pkg::sshr24({1'b0, z0amp_s3}, side_s3.z0[31]))
		: rd_s3;
	assign coef_full = cnes_pkg::shr24({8'd0, ampcomp_s3});

	// stage 4: products
	logic signed [32:0] fe;
	logic [32:0]        fe_mag;

	assign fe     = {side_s4.f[31], side_s4.f} + {eps_s4[31], eps_s4};
	assign fe_mag = fe[32] ? 33'(-fe) : 33'(fe);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3    <= rside;
			z0amp_s3   <= cnes_pkg::mag32(rside.z0) * amp;
			ampcomp_s3 <= amp * comp;

			side_s4 <= side_s3;
			eps_s4  <= eps;
			coef_s4 <= coef_full[31:0];

			idx_s5   <= side_s4.idx;
			x_s5     <= side_s4.x;
			last_s5  <= side_s4.last;
			stamp_s5 <= side_s4.stamp;
			p1_s5    <= fe_mag * step_q;
			p1neg_s5 <= fe[32];
			p2_s5    <= cnes_pkg::mag32(eps_s4) * decay_q;
			p2neg_s5 <= eps_s4[31];
			p3_s5    <= cnes_pkg::mag32(side_s4.z) * coef_s4;
			p3neg_s5 <= side_s4.z[31];
		end
	end

	// stage 5: round, sum, saturate
	logic signed [31:0] nv;

	assign nv = cnes_pkg::sat32({{10{x_s5[31]}}, x_s5} + cnes_pkg::sshr24(p1_s5, p1neg_s5));
	assign ne = cnes_pkg::sat32(cnes_pkg::sshr24({7'd0, p2_s5}, p2neg_s5)
		+ cnes_pkg::sshr24(p3_s5, p3neg_s5));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_index <= idx_s5;
			new_value <= nv;
			out_last  <= last_s5;
			sim_time  <= stamp_s5;
		end
	end

	assign out_valid = out_valid_q;

	// an element never sits in two read-modify-write stages at once
	a_no_dup_34: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && v_s4 |-> side_s3.idx != side_s4.idx) else $error("dup idx s3/s4");
	a_no_dup_35: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && v_s5 |-> side_s3.idx != idx_s5) else $error("dup idx s3/s5");
	a_no_dup_45: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && v_s5 |-> side_s4.idx != idx_s5) else $error("dup idx s4/s5");
	a_hold_wb: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s5) && $stable(idx_s5)) else $error("writeback moved in stall");

endmodule
